FILE: hw/rtl/gfmi_pkg.sv
// ----------------------------------------------------------------------------
// gfmi_pkg
// shared types and constants of the gf(2^8) matrix inverter
// ----------------------------------------------------------------------------
package gfmi_pkg;
   localparam int unsigned ElemW  = 8;
   localparam int unsigned IdxW   = 3;
   localparam int unsigned SizeW  = 4;
   localparam int unsigned PolyW  = 9;

   localparam logic [0:0] CsrMatrixSize = 1'b0;
   localparam logic [0:0] CsrFieldPoly  = 1'b1;

   localparam logic KindLoad   = 1'b0;
   localparam logic KindInvert = 1'b1;

   // operands of the shared multiplier
   typedef struct packed {
      logic [ElemW-1:0] a;
      logic [ElemW-1:0] b;
   } mul_req_type;
endpackage

FILE: hw/rtl/gfmi_mul.sv
// ----------------------------------------------------------------------------
// gfmi_mul
// combinational gf(2^8) multiplier, reduced by the low bits of the polynomial
// ----------------------------------------------------------------------------
module gfmi_mul (
   input  gfmi_pkg::mul_req_type     req,
   input  logic [7:0]                poly,
   output logic [7:0]                prod
);
   import gfmi_pkg::*;

   always_comb begin
      logic [7:0] x;
      logic [7:0] r;
      x = req.a;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (req.b[i]) begin
            r = r ^ x;
         end
         x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
      end
      prod = r;
   end
endmodule

FILE: hw/rtl/gf256_matrix_invert.sv
// ----------------------------------------------------------------------------
// gf256_matrix_invert
// gauss-jordan inversion of a square matrix over gf(2^8)
// ----------------------------------------------------------------------------
// Load items (kind 0) write one element. An invert item (kind 1) builds [A|I]
// in a 2*MAX_N column memory and eliminates it with one shared field
// multiplier and one memory with a registered read port. That port sets the
// pace. A scale step works over the 2n columns in use, and a row operation
// works over them element by element (read source, read destination, write
// back). A row swap works over all 2*MAX_N columns. The pivot inverse is
// a^254, built from 15 products on the same multiplier. Then come the n*n
// results, or one singular result. Each result is loaded into the output
// register when that register is empty or being taken. The block is not ready
// until the last result has been taken.
// ----------------------------------------------------------------------------
module gf256_matrix_invert #(
   parameter int unsigned MAX_N = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // row[2:0], col[5:3], value[13:6], zero pad
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_row[2:0], out_col[5:3], out_value[13:6], pad
   output logic [0:0]  rsp_tuser,   // singular
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import gfmi_pkg::*;

   localparam int unsigned CW = $clog2(2 * MAX_N);
   localparam int unsigned RW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int unsigned Depth = MAX_N * 2 * MAX_N;

   localparam logic [3:0] SIdle = 4'd0, SIdent = 4'd1, SPivRd = 4'd2, SSearch = 4'd3,
      SSwap = 4'd4, SInv = 4'd5, SScale = 4'd6, SFacRd = 4'd7, SRowOp = 4'd8,
      SNext = 4'd9, SOut = 4'd10, SSing = 4'd11, SWait = 4'd12;

   logic [SizeW-1:0] size_ff;
   logic [7:0]       poly_ff;
   logic [3:0]       state_ff;
   logic [RW-1:0]    n1_ff;      // n - 1
   logic [RW-1:0]    r_ff, k_ff;
   logic [CW:0]      c_ff;
   logic [1:0]       ph_ff;
   logic             pass2_ff;
   logic [7:0]       fac_ff, inv_ff, base_ff, tmp_ff;
   logic [3:0]       e_ff;
   logic [7:0]       mem [Depth];
   logic [7:0]       rd_ff;
   logic             rsp_v_ff;
   logic [IdxW-1:0]  or_ff, oc_ff;
   logic [7:0]       ov_ff;
   logic             ol_ff, os_ff;
   logic             rsp_load;

   mul_req_type mreq;
   logic [7:0]  mprod;
   gfmi_mul u_mul (.req(mreq), .poly(poly_ff), .prod(mprod));

   function automatic logic [$clog2(Depth)-1:0] addr(input logic [RW-1:0] r,
                                                    input logic [CW-1:0] c);
      return $clog2(Depth)'(r * 2 * MAX_N + c);
   endfunction

   logic [RW:0] n_w;
   assign n_w = {1'b0, n1_ff} + 1'b1;
   logic [CW:0] cols_w;
   assign cols_w = (CW+1)'(2 * n_w);

   logic        we;
   logic [$clog2(Depth)-1:0] wa, ra;
   logic [7:0]  wd;

   always_comb begin
      we = 1'b0; wa = '0; wd = '0; ra = '0;
      mreq.a = fac_ff; mreq.b = rd_ff;
      unique case (state_ff)
         SIdle: begin
            we = req_tvalid && req_tuser == KindLoad && rsp_v_ff == 1'b0;
            wa = addr(RW'(req_tdata[2:0]), CW'(req_tdata[5:3]));
            wd = req_tdata[13:6];
         end
         SIdent: begin
            we = 1'b1;
            wa = addr(r_ff, CW'(n_w + RW'(k_ff)));
            wd = {7'd0, r_ff == k_ff};
         end
         SPivRd: ra = addr(r_ff, CW'(r_ff));
         SSearch: ra = addr(k_ff, CW'(r_ff));
         SSwap: begin
            // ph 0 read k, ph 1 write r and read r, ph 2 read r, ph 3 write k
            ra = (ph_ff == 2'd0) ? addr(k_ff, c_ff[CW-1:0]) : addr(r_ff, c_ff[CW-1:0]);
            we = ph_ff[0];
            wa = (ph_ff == 2'd1) ? addr(r_ff, c_ff[CW-1:0]) : addr(k_ff, c_ff[CW-1:0]);
            wd = (ph_ff == 2'd1) ? rd_ff : tmp_ff;
         end
         SInv: begin
            mreq.a = ph_ff[0] ? inv_ff : base_ff;
            mreq.b = base_ff;
         end
         SScale: begin
            ra = addr(r_ff, c_ff[CW-1:0]);
            mreq.a = inv_ff;
            we = ph_ff[0];
            wa = addr(r_ff, c_ff[CW-1:0]);
            wd = mprod;
         end
         SFacRd: ra = addr(k_ff, CW'(r_ff));
         SRowOp: begin
            // ph 0 read src, ph 1 read dst, ph 2 write dst
            ra = ph_ff[0] ? addr(k_ff, c_ff[CW-1:0]) : addr(r_ff, c_ff[CW-1:0]);
            we = ph_ff == 2'd2;
            wa = addr(k_ff, c_ff[CW-1:0]);
            mreq.b = tmp_ff;
            wd = rd_ff ^ mprod;
         end
         SOut: ra = addr(r_ff, CW'(n_w + RW'(k_ff)));
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   assign req_tready = (state_ff == SIdle) && !rsp_v_ff;

   // a new result goes into the output register when it is empty or being taken
   assign rsp_load = ((state_ff == SOut && ph_ff != 2'd0) || state_ff == SSing) &&
                     (!rsp_v_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= 4'd8; poly_ff <= 8'h1D; state_ff <= SIdle; rsp_v_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CsrMatrixSize) size_ff <= csr_wdata[3:0];
         if (csr_we && csr_index == CsrFieldPoly) poly_ff <= csr_wdata[7:0];
         if (rsp_load) rsp_v_ff <= 1'b1;
         else if (rsp_tready) rsp_v_ff <= 1'b0;
         unique case (state_ff)
            SIdle: if (req_tvalid && req_tready && req_tuser == KindInvert) begin
               n1_ff <= (size_ff == 0) ? '0 : (size_ff > MAX_N) ? RW'(MAX_N - 1)
                        : RW'(size_ff - 1'b1);
               r_ff <= '0; k_ff <= '0; pass2_ff <= 1'b0; state_ff <= SIdent;
            end
            SIdent: begin
               if (k_ff == n1_ff) begin
                  k_ff <= '0;
                  if (r_ff == n1_ff) begin r_ff <= '0; state_ff <= SPivRd; end
                  else r_ff <= r_ff + 1'b1;
               end else k_ff <= k_ff + 1'b1;
               ph_ff <= '0;
            end
            SPivRd: begin
               if (ph_ff == 0) ph_ff <= 2'd1;
               else begin
                  ph_ff <= '0; c_ff <= '0;
                  if (rd_ff == 0) begin
                     if (r_ff == n1_ff) state_ff <= SSing;
                     else begin k_ff <= r_ff + 1'b1; state_ff <= SSearch; end
                  end else if (rd_ff == 8'd1) begin
                     k_ff <= r_ff + 1'b1;
                     state_ff <= (r_ff == n1_ff) ? SNext : SFacRd;
                  end else begin
                     base_ff <= rd_ff; inv_ff <= 8'd1; e_ff <= '0; state_ff <= SInv;
                  end
               end
            end
            SSearch: begin
               if (ph_ff == 0) ph_ff <= 2'd1;
               else begin
                  ph_ff <= '0;
                  if (rd_ff != 0) state_ff <= SSwap;
                  else if (k_ff == n1_ff) state_ff <= SSing;
                  else k_ff <= k_ff + 1'b1;
               end
            end
            SSwap: begin
               if (ph_ff == 2'd0) ph_ff <= 2'd1;
               else if (ph_ff == 2'd1) begin tmp_ff <= rd_ff; ph_ff <= 2'd2; end
               else if (ph_ff == 2'd2) begin tmp_ff <= rd_ff; ph_ff <= 2'd3; end
               else begin
                  ph_ff <= '0;
                  // whole rows trade places, including columns outside the used size
                  if (c_ff == (CW+1)'(2 * MAX_N - 1)) begin
                     c_ff <= '0; state_ff <= SPivRd;
                  end else c_ff <= c_ff + 1'b1;
               end
            end
            SInv: begin
               // a^254: bits 1..7 of 254 are set, bit 0 clear
               if (ph_ff[0]) begin inv_ff <= mprod; ph_ff <= 2'd0; end
               else begin
                  base_ff <= mprod; e_ff <= e_ff + 1'b1;
                  if (e_ff == 4'd7) begin
                     ph_ff <= '0; c_ff <= '0; state_ff <= SScale;
                  end else ph_ff <= 2'd1;
               end
            end
            SScale: begin
               if (ph_ff == 0) ph_ff <= 2'd1;
               else begin
                  ph_ff <= '0;
                  if (c_ff == cols_w - 1'b1) begin
                     c_ff <= '0; k_ff <= r_ff + 1'b1;
                     state_ff <= (r_ff == n1_ff) ? SNext : SFacRd;
                  end else c_ff <= c_ff + 1'b1;
               end
            end
            SFacRd: begin
               if (ph_ff == 0) ph_ff <= 2'd1;
               else begin
                  ph_ff <= '0; c_ff <= '0; fac_ff <= rd_ff;
                  if (rd_ff != 0) state_ff <= SRowOp;
                  else if (!pass2_ff && k_ff != n1_ff) k_ff <= k_ff + 1'b1;
                  else if (pass2_ff && k_ff + 1'b1 != r_ff) k_ff <= k_ff + 1'b1;
                  else state_ff <= SNext;
               end
            end
            SRowOp: begin
               if (ph_ff == 2'd0) ph_ff <= 2'd1;
               else if (ph_ff == 2'd1) begin tmp_ff <= rd_ff; ph_ff <= 2'd2; end
               else begin
                  ph_ff <= '0;
                  if (c_ff == cols_w - 1'b1) begin
                     c_ff <= '0;
                     if (!pass2_ff && k_ff != n1_ff) begin
                        k_ff <= k_ff + 1'b1; state_ff <= SFacRd;
                     end else if (pass2_ff && k_ff + 1'b1 != r_ff) begin
                        k_ff <= k_ff + 1'b1; state_ff <= SFacRd;
                     end else state_ff <= SNext;
                  end else c_ff <= c_ff + 1'b1;
               end
            end
            SNext: begin
               ph_ff <= '0;
               if (!pass2_ff) begin
                  if (r_ff == n1_ff) begin
                     pass2_ff <= 1'b1;
                     if (n1_ff == 0) begin r_ff <= '0; k_ff <= '0; state_ff <= SOut; end
                     else begin r_ff <= RW'(1); k_ff <= '0; state_ff <= SFacRd; end
                  end else begin r_ff <= r_ff + 1'b1; state_ff <= SPivRd; end
               end else if (r_ff == n1_ff) begin
                  r_ff <= '0; k_ff <= '0; state_ff <= SOut;
               end else begin
                  r_ff <= r_ff + 1'b1; k_ff <= '0; state_ff <= SFacRd;
               end
            end
            SOut: begin
               if (ph_ff == 0) ph_ff <= 2'd1;
               else if (rsp_load) begin
                  ov_ff <= rd_ff; os_ff <= 1'b0;
                  or_ff <= IdxW'(r_ff); oc_ff <= IdxW'(k_ff);
                  ol_ff <= (r_ff == n1_ff) && (k_ff == n1_ff);
                  ph_ff <= '0;
                  if (k_ff == n1_ff) begin
                     k_ff <= '0;
                     if (r_ff == n1_ff) state_ff <= SWait;
                     else r_ff <= r_ff + 1'b1;
                  end else k_ff <= k_ff + 1'b1;
               end
            end
            SSing: if (rsp_load) begin
               ov_ff <= '0; or_ff <= '0; oc_ff <= '0;
               ol_ff <= 1'b1; os_ff <= 1'b1; state_ff <= SWait;
            end
            SWait: state_ff <= SIdle;
            default: state_ff <= SIdle;
         endcase
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {2'b00, ov_ff, oc_ff, or_ff};
   assign rsp_tuser  = os_ff;
   assign rsp_tlast  = ol_ff;

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != SIdle) |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata)) else $error("rsp moved");
   a_sing: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tlast) else $error("singular not last");
endmodule
